[rtl/core/kl_pkg.sv]
`timescale 1ns / 1ps

package kl_pkg;

   // token kinds
   localparam logic [3:0] KIND_RETURN  = 4'd0;
   localparam logic [3:0] KIND_EXIT    = 4'd1;
   localparam logic [3:0] KIND_INT     = 4'd2;
   localparam logic [3:0] KIND_NUMBER  = 4'd3;
   localparam logic [3:0] KIND_IDENT   = 4'd4;
   localparam logic [3:0] KIND_OPAREN  = 4'd5;
   localparam logic [3:0] KIND_CPAREN  = 4'd6;
   localparam logic [3:0] KIND_SEMI    = 4'd7;
   localparam logic [3:0] KIND_EQ      = 4'd8;
   localparam logic [3:0] KIND_END     = 4'd9;
   localparam logic [3:0] KIND_BADNUM  = 4'd10;
   localparam logic [3:0] KIND_BADCHAR = 4'd11;

   // character bytes: single-character tokens, the NUL end marker and space
   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_OPAREN = 8'h28;
   localparam logic [7:0] CHAR_CPAREN = 8'h29;
   localparam logic [7:0] CHAR_SEMI   = 8'h3B;
   localparam logic [7:0] CHAR_EQ     = 8'h3D;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;

   // keyword candidates: 0 "return", 1 "ret", 2 "exit", 3 "int"
   localparam int NUM_KW = 4;

   // record queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [3:0]  token_kind;
      logic [15:0] start_offset;
      logic [7:0]  token_length;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [15:0] start;
      logic [7:0]  length;
   } tok_type;

   // everything one input item produces: an optional flushed word and its own token
   typedef struct packed {
      logic    has_word;
      tok_type word;
      logic    has_own;
      tok_type own;
   } record_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic logic [2:0] kw_len(input logic [1:0] k);
      logic [2:0] r;
      unique case (k)
         2'd0: r = 3'd6;
         2'd1: r = 3'd3;
         2'd2: r = 3'd4;
         2'd3: r = 3'd3;
         default: r = 3'd0;
      endcase
      return r;
   endfunction

   function automatic logic [3:0] kw_kind(input logic [1:0] k);
      logic [3:0] r;
      unique case (k)
         2'd0: r = KIND_RETURN;
         2'd1: r = KIND_RETURN;
         2'd2: r = KIND_EXIT;
         2'd3: r = KIND_INT;
         default: r = KIND_IDENT;
      endcase
      return r;
   endfunction

   // keyword character at index i; only read below the keyword's length
   function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] i);
      logic [47:0] txt;
      logic [7:0]  r;
      unique case (k)
         2'd0: txt = {"n", "r", "u", "t", "e", "r"};
         2'd1: txt = {24'h0, "t", "e", "r"};
         2'd2: txt = {16'h0, "t", "i", "x", "e"};
         2'd3: txt = {24'h0, "t", "n", "i"};
         default: txt = '0;
      endcase
      unique case (i)
         3'd0: r = txt[7:0];
         3'd1: r = txt[15:8];
         3'd2: r = txt[23:16];
         3'd3: r = txt[31:24];
         3'd4: r = txt[39:32];
         3'd5: r = txt[47:40];
         default: r = 8'h00;
      endcase
      return r;
   endfunction

endpackage

[rtl/core/kl_front.sv]
`timescale 1ns / 1ps

module kl_front #(
   parameter int MAX_WORD_LEN = 255,
   parameter int MAX_TEXT_LEN = 65536
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   input  kl_pkg::req_type     item,
   output logic                rec_push,
   output kl_pkg::record_type  rec
);
   import kl_pkg::*;

   localparam int LEN_W = $clog2(MAX_WORD_LEN + 1);
   localparam int POS_W = $clog2(MAX_TEXT_LEN);
   localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(MAX_WORD_LEN);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_TEXT_LEN - 1);

   logic [POS_W-1:0] position_ff, position_in;
   logic             in_word_ff, in_word_in;
   logic [POS_W-1:0] word_start_ff, word_start_in;
   logic [LEN_W-1:0] word_length_ff, word_length_in;
   logic             first_digit_ff, first_digit_in;
   logic             rest_digits_ff, rest_digits_in;
   logic [NUM_KW-1:0] alive_ff, alive_in;
   logic             halted_ff, halted_in;

   logic [7:0]        c;
   logic              is_end, is_digit, is_alnum, is_space, stop;
   logic [LEN_W-1:0]  cur_len;
   logic [NUM_KW-1:0] cur_alive, kill;
   logic [POS_W-1:0]  next_pos;
   logic [3:0]        word_kind;
   logic [POS_W+15:0] pos_ext, start_ext;
   logic [LEN_W+7:0]  len_ext;
   logic [7:0]        word_len8;

   assign c        = item.char_code;
   assign is_end   = item.end_of_text | (c == CHAR_NUL);
   assign is_digit = (c >= "0") && (c <= "9");
   assign is_alnum = is_digit || ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
   assign is_space = (c == CHAR_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));

   assign cur_len   = in_word_ff ? word_length_ff : '0;
   assign cur_alive = in_word_ff ? alive_ff : '1;
   assign next_pos  = (position_ff == POS_LAST) ? '0 : position_ff + POS_W'(1);

   // incremental keyword match: drop a candidate on length or character mismatch
   always_comb begin
      for (int i = 0; i < NUM_KW; i++) begin
         kill[i] = (cur_len >= LEN_W'(kw_len(2'(i)))) || (kw_char(2'(i), cur_len[2:0]) != c);
      end
   end

   always_comb begin
      priority if (alive_ff[0] && (word_length_ff == LEN_W'(kw_len(2'd0))))
         word_kind = kw_kind(2'd0);
      else if (alive_ff[1] && (word_length_ff == LEN_W'(kw_len(2'd1))))
         word_kind = kw_kind(2'd1);
      else if (alive_ff[2] && (word_length_ff == LEN_W'(kw_len(2'd2))))
         word_kind = kw_kind(2'd2);
      else if (alive_ff[3] && (word_length_ff == LEN_W'(kw_len(2'd3))))
         word_kind = kw_kind(2'd3);
      else if (first_digit_ff)
         word_kind = rest_digits_ff ? KIND_NUMBER : KIND_BADNUM;
      else
         word_kind = KIND_IDENT;
   end

   assign pos_ext   = {16'h0, position_ff};
   assign start_ext = {16'h0, word_start_ff};
   assign len_ext   = {8'h0, word_length_ff};
   assign word_len8 = (len_ext > (LEN_W+8)'(255)) ? 8'hFF : len_ext[7:0];

   always_comb begin
      position_in    = position_ff;
      in_word_in     = in_word_ff;
      word_start_in  = word_start_ff;
      word_length_in = word_length_ff;
      first_digit_in = first_digit_ff;
      rest_digits_in = rest_digits_ff;
      alive_in       = alive_ff;
      halted_in      = halted_ff;
      rec            = '0;
      rec_push       = 1'b0;
      stop           = 1'b0;
      if (item_valid && !halted_ff) begin
         if (!is_end && is_alnum) begin
            in_word_in = 1'b1;
            if (!in_word_ff) begin
               word_start_in  = position_ff;
               first_digit_in = is_digit;
               rest_digits_in = 1'b1;
            end else if (!is_digit) begin
               rest_digits_in = 1'b0;
            end
            alive_in       = cur_alive & ~kill;
            word_length_in = (cur_len < LEN_MAX) ? cur_len + LEN_W'(1) : cur_len;
            position_in    = next_pos;
         end else begin
            if (in_word_ff) begin
               rec.has_word    = 1'b1;
               rec.word.kind   = word_kind;
               rec.word.start  = start_ext[15:0];
               rec.word.length = word_len8;
               in_word_in      = 1'b0;
               word_start_in   = '0;
               word_length_in  = '0;
               first_digit_in  = 1'b0;
               rest_digits_in  = 1'b1;
               alive_in        = '1;
               if (word_kind == KIND_BADNUM) begin
                  // bad number ends the run; the delimiter is dropped
                  halted_in = 1'b1;
                  stop      = 1'b1;
               end
            end
            if (!stop) begin
               rec.own.start = pos_ext[15:0];
               if (is_end) begin
                  rec.has_own    = 1'b1;
                  rec.own.kind   = KIND_END;
                  rec.own.length = 8'd0;
                  halted_in      = 1'b1;
               end else begin
                  rec.own.length = 8'd1;
                  rec.has_own    = 1'b1;
                  unique case (c)
                     CHAR_OPAREN: rec.own.kind = KIND_OPAREN;
                     CHAR_CPAREN: rec.own.kind = KIND_CPAREN;
                     CHAR_SEMI:   rec.own.kind = KIND_SEMI;
                     CHAR_EQ:     rec.own.kind = KIND_EQ;
                     default: begin
                        rec.own.kind = KIND_BADCHAR;
                        if (is_space) begin
                           rec.has_own = 1'b0;
                        end else begin
                           halted_in = 1'b1;
                        end
                     end
                  endcase
                  position_in = next_pos;
               end
            end
            rec_push = rec.has_word | rec.has_own;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff    <= '0;
         in_word_ff     <= 1'b0;
         word_start_ff  <= '0;
         word_length_ff <= '0;
         first_digit_ff <= 1'b0;
         rest_digits_ff <= 1'b1;
         alive_ff       <= '1;
         halted_ff      <= 1'b0;
      end else begin
         position_ff    <= position_in;
         in_word_ff     <= in_word_in;
         word_start_ff  <= word_start_in;
         word_length_ff <= word_length_in;
         first_digit_ff <= first_digit_in;
         rest_digits_ff <= rest_digits_in;
         alive_ff       <= alive_in;
         halted_ff      <= halted_in;
      end
   end

endmodule

[rtl/core/kl_queue.sv]
`timescale 1ns / 1ps

module kl_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  kl_pkg::record_type   push_data,
   input  logic                 pop,
   output kl_pkg::record_type   pop_data,
   output kl_pkg::q_status_type status
);
   import kl_pkg::*;

   record_type       entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + QCNT_W'(1);
         2'b01:   count_in = count_ff - QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/core/kl_back.sv]
`timescale 1ns / 1ps

module kl_back (
   input  logic                 clock,
   input  logic                 reset,
   input  kl_pkg::q_status_type q_status,
   input  kl_pkg::record_type   q_data,
   output logic                 q_pop,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output kl_pkg::rsp_type      rsp_data
);
   import kl_pkg::*;

   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff, out_in;
   logic    pend_valid_ff, pend_valid_in;
   rsp_type pend_ff, pend_in;
   logic    load;

   assign load      = !out_valid_ff || rsp_pop;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      q_pop         = 1'b0;
      if (load) begin
         if (pend_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = pend_ff;
            pend_valid_in = 1'b0;
         end else if (!q_status.empty) begin
            q_pop        = 1'b1;
            out_valid_in = 1'b1;
            if (q_data.has_word) begin
               out_in = '{q_data.word.kind, q_data.word.start, q_data.word.length,
                          !q_data.has_own};
               if (q_data.has_own) begin
                  pend_valid_in = 1'b1;
                  pend_in = '{q_data.own.kind, q_data.own.start, q_data.own.length, 1'b1};
               end
            end else begin
               out_in = '{q_data.own.kind, q_data.own.start, q_data.own.length, 1'b1};
            end
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      pend_ff <= pend_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

endmodule

[rtl/core/keyword_lexer_top.sv]
`timescale 1ns / 1ps
// Channel   Ports                          Transaction when
// -------   -----------------------------  ---------------------------------
// request   req_push req_full req_data     req_push && !req_full at clock edge
// response  rsp_empty rsp_pop rsp_data     rsp_pop && !rsp_empty at clock edge
//
// One request transaction per cycle while req_full is low; the front decides
// each byte in the cycle it is taken. A byte yields zero, one or two tokens;
// the back drains one token per cycle while responses are popped, so a two-token
// byte holds the output reg for both tokens in turn. A request's record is
// written to the queue at the request edge, then loaded into the output reg.
// reset is synchronous, active high; it clears word state, position, halt,
// the queue and the output stage. req_full rises only when the 4-entry queue
// fills under response back-pressure. After a bad token or end of text the
// lexer keeps taking bytes and drops them until reset.

module keyword_lexer_top #(
   parameter int MAX_WORD_LEN = 255,
   parameter int MAX_TEXT_LEN = 65536
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_push,
   output logic            req_full,
   input  kl_pkg::req_type req_data,
   output logic            rsp_empty,
   input  logic            rsp_pop,
   output kl_pkg::rsp_type rsp_data
);
   import kl_pkg::*;

   q_status_type q_status;
   record_type   front_rec, q_data;
   logic         front_push, q_pop, req_taken;

   // queue full is the only source of input back-pressure
   assign req_full  = q_status.full;
   assign req_taken = req_push && !req_full;

   // front: byte classification, word tracking, keyword match
   kl_front #(
      .MAX_WORD_LEN(MAX_WORD_LEN),
      .MAX_TEXT_LEN(MAX_TEXT_LEN)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .item_valid (req_taken),
      .item       (req_data),
      .rec_push   (front_push),
      .rec        (front_rec)
   );

   // decoupling queue: one record per token-producing byte
   kl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_rec),
      .pop       (q_pop),
      .pop_data  (q_data),
      .status    (q_status)
   );

   // back: splits records into tokens, output register
   kl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

`ifndef ASSERT_OFF
   // front never produces a record while the queue is full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(front_push && q_status.full))
      else $error("record pushed into full queue");

   // terminal tokens always close their run
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_data.token_kind == KIND_END || rsp_data.token_kind == KIND_BADCHAR
       || rsp_data.token_kind == KIND_BADNUM)) |-> rsp_data.last_of_run)
      else $error("terminal token without last_of_run");

   // a non-final token of a run is always a word token
   a_first_is_word: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.last_of_run) |->
      (rsp_data.token_kind == KIND_RETURN || rsp_data.token_kind == KIND_EXIT
       || rsp_data.token_kind == KIND_INT || rsp_data.token_kind == KIND_NUMBER
       || rsp_data.token_kind == KIND_IDENT))
      else $error("non-word token not last of run");

   // output stage empties on reset
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("response pending after reset");
`endif

endmodule
